@@ rtl/apic_pkg.sv @@
package apic_pkg;

   // number of dimension fields on the ports and in the register file
   localparam int unsigned NumDims = 4;
   localparam int unsigned SizeWidth = 16;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned CsrIndexWidth = 3;

   // register indexes of the configuration port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DIM_COUNT  = 3'd0,
      CSR_DIM_SIZE_0 = 3'd1,
      CSR_DIM_SIZE_1 = 3'd2,
      CSR_DIM_SIZE_2 = 3'd3,
      CSR_DIM_SIZE_3 = 3'd4
   } csr_index_type;

   // configuration as the datapath sees it: effective count and nonzero divisors
   typedef struct packed {
      logic [CountWidth-1:0]                dim_num;
      logic [NumDims-1:0][SizeWidth-1:0]    divisor;
   } cfg_type;

endpackage

@@ rtl/apic_csr.sv @@
module apic_csr
   import apic_pkg::*;
#(
   parameter int unsigned MAX_DIMS = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [SizeWidth-1:0]     csr_wdata,
   output cfg_type                  cfg
);

   localparam int unsigned LimDims = (MAX_DIMS < NumDims) ? MAX_DIMS : NumDims;
   localparam logic [CountWidth-1:0] LimCount = CountWidth'(LimDims);

   logic [CountWidth-1:0]             dim_count_ff;
   logic [NumDims-1:0][SizeWidth-1:0] dim_size_ff;

   // write registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= CountWidth'(1);
         for (int i = 0; i < NumDims; i++) begin
            dim_size_ff[i] <= SizeWidth'(1);
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIM_COUNT:  dim_count_ff   <= csr_wdata[CountWidth-1:0];
            CSR_DIM_SIZE_0: dim_size_ff[0] <= csr_wdata;
            CSR_DIM_SIZE_1: dim_size_ff[1] <= csr_wdata;
            CSR_DIM_SIZE_2: dim_size_ff[2] <= csr_wdata;
            CSR_DIM_SIZE_3: dim_size_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the count to one..limit, treat a zero size as one
   always_comb begin
      if (dim_count_ff == '0) begin
         cfg.dim_num = CountWidth'(1);
      end else if (dim_count_ff > LimCount) begin
         cfg.dim_num = LimCount;
      end else begin
         cfg.dim_num = dim_count_ff;
      end
      for (int i = 0; i < NumDims; i++) begin
         cfg.divisor[i] = (dim_size_ff[i] == '0) ? SizeWidth'(1) : dim_size_ff[i];
      end
   end

endmodule

@@ rtl/array_position_index_converter_top.sv @@
// Column-major position / index converter.
// Input channel req_*: func 0 splits req_position_in into one-based indices,
// func 1 folds req_index_in_* into a zero-based position. Result channel rsp_*
// carries one word per accepted input word, in order; unused fields read zero.
// Configuration csr_*: write dim_count (index 0) and dim_size_0..3 (1..4)
// only while no word is in flight; writes take effect at once.
// Each of the min(MAX_DIMS,4) dimensions is one restoring divider of
// POSITION_WIDTH stages, one quotient bit per stage; the multiply-add for
// func 1 rides in the first two stages of each dimension.
// Throughput: one word per cycle. The whole pipeline advances together; when
// the receiver holds rsp_ready low with a result waiting, every stage holds
// and req_ready drops, so nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and sets dim_count
// and all sizes to one.
module array_position_index_converter_top
   import apic_pkg::*;
#(
   parameter int unsigned MAX_DIMS       = 4,
   parameter int unsigned POSITION_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [31:0]              req_position_in,
   input  logic [SizeWidth-1:0]     req_index_in_0,
   input  logic [SizeWidth-1:0]     req_index_in_1,
   input  logic [SizeWidth-1:0]     req_index_in_2,
   input  logic [SizeWidth-1:0]     req_index_in_3,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_position_out,
   output logic [SizeWidth-1:0]     rsp_index_out_0,
   output logic [SizeWidth-1:0]     rsp_index_out_1,
   output logic [SizeWidth-1:0]     rsp_index_out_2,
   output logic [SizeWidth-1:0]     rsp_index_out_3,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [SizeWidth-1:0]     csr_wdata
);

   localparam int unsigned PW      = POSITION_WIDTH;
   localparam int unsigned LimDims = (MAX_DIMS < NumDims) ? MAX_DIMS : NumDims;
   localparam int unsigned NumStages = LimDims * PW;

   typedef struct packed {
      logic                              func;
      logic [PW-1:0]                     work;
      logic [SizeWidth-1:0]              rem;
      logic [PW-1:0]                     acc;
      logic [PW-1:0]                     scaled;
      logic [PW-1:0]                     stride;
      logic [NumDims-1:0][SizeWidth-1:0] idx_in;
      logic [NumDims-1:0][SizeWidth-1:0] idx_out;
   } stage_type;

   cfg_type   cfg;
   logic      advance;
   stage_type entry;
   logic      [PW-1:0] entry_work;
   logic      [NumStages-1:0] valid_ff;
   stage_type st_ff [NumStages];
   stage_type st_in [NumStages];

   apic_csr #(
      .MAX_DIMS (MAX_DIMS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stall everything while the last stage holds an untaken word
   assign advance   = !valid_ff[NumStages-1] || rsp_ready;
   assign req_ready = advance;

   // build the entry word from the ports
   always_comb begin
      entry        = '0;
      entry.func   = req_func;
      entry.stride = PW'(1);
      entry.idx_in = {req_index_in_3, req_index_in_2, req_index_in_1, req_index_in_0};
   end

   generate
      if (PW >= 32) begin : g_pos_wide
         always_comb begin
            entry_work = PW'(req_position_in);
         end
      end else begin : g_pos_narrow
         always_comb begin
            entry_work = req_position_in[PW-1:0];
         end
      end
   endgenerate

   // one divider bit per stage, plus the multiply-add at the head of each dimension
   generate
      for (genvar s = 0; s < NumStages; s++) begin : g_stage
         localparam int unsigned K = s / PW;
         localparam int unsigned J = s % PW;
         localparam logic [CountWidth-1:0] KCount = CountWidth'(K);

         stage_type                src;
         logic [SizeWidth:0]       r_shift;
         logic [SizeWidth:0]       r_diff;
         logic                     ge;
         logic [PW+SizeWidth-1:0]  prod;
         logic [SizeWidth-1:0]     rem_nx;

         always_comb begin
            if (s == 0) begin
               src      = entry;
               src.work = entry_work;
            end else begin
               src = st_ff[(s == 0) ? 0 : s-1];
            end
         end

         always_comb begin
            st_in[s] = src;
            // shift in the next dividend bit and try the subtract
            r_shift  = {((J == 0) ? {SizeWidth{1'b0}} : src.rem), src.work[PW-1]};
            r_diff   = r_shift - {1'b0, cfg.divisor[K]};
            ge       = (r_shift >= {1'b0, cfg.divisor[K]});
            rem_nx   = ge ? r_diff[SizeWidth-1:0] : r_shift[SizeWidth-1:0];
            st_in[s].rem  = rem_nx;
            st_in[s].work = {src.work[PW-2:0], ge};
            prod = '0;
            if (J == 0) begin
               prod = src.stride * src.idx_in[K];
               st_in[s].scaled = prod[PW-1:0];
            end
            if (J == 1) begin
               prod = src.stride * cfg.divisor[K];
               if (KCount < cfg.dim_num) begin
                  st_in[s].acc = src.acc + src.scaled - src.stride;
               end
               st_in[s].stride = prod[PW-1:0];
            end
            if (J == PW-1) begin
               st_in[s].idx_out[K] = (KCount < cfg.dim_num) ?
                                     rem_nx + SizeWidth'(1) : '0;
            end
         end

         // advance valid and payload together
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= (s == 0) ? req_valid : valid_ff[(s == 0) ? 0 : s-1];
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               st_ff[s] <= st_in[s];
            end
         end
      end
   endgenerate

   // drive the result fields; the other function's fields read zero
   assign rsp_valid = valid_ff[NumStages-1];

   generate
      if (PW >= 32) begin : g_out_wide
         assign rsp_position_out = st_ff[NumStages-1].func ?
                                   st_ff[NumStages-1].acc[31:0] : 32'd0;
      end else begin : g_out_narrow
         assign rsp_position_out = st_ff[NumStages-1].func ?
                                   32'(st_ff[NumStages-1].acc) : 32'd0;
      end
   endgenerate

   assign rsp_index_out_0 = st_ff[NumStages-1].func ? '0 : st_ff[NumStages-1].idx_out[0];
   assign rsp_index_out_1 = st_ff[NumStages-1].func ? '0 : st_ff[NumStages-1].idx_out[1];
   assign rsp_index_out_2 = st_ff[NumStages-1].func ? '0 : st_ff[NumStages-1].idx_out[2];
   assign rsp_index_out_3 = st_ff[NumStages-1].func ? '0 : st_ff[NumStages-1].idx_out[3];

endmodule

@@ rtl/apic_checker.sv @@
module apic_checker
   import apic_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [31:0]          rsp_position_out,
   input logic [SizeWidth-1:0] rsp_index_out_0,
   input logic [SizeWidth-1:0] rsp_index_out_1,
   input logic [SizeWidth-1:0] rsp_index_out_2,
   input logic [SizeWidth-1:0] rsp_index_out_3
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped under stall");

   // the input side only stalls when a result waits untaken
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   // a result carries either a position or indices, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position_out == 32'd0) ||
                    (rsp_index_out_0 == '0 && rsp_index_out_1 == '0 &&
                     rsp_index_out_2 == '0 && rsp_index_out_3 == '0))
      else $error("position and index fields both set");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind array_position_index_converter_top apic_checker u_apic_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb
   import apic_pkg::*;
();

   localparam int unsigned LATENCY = 4 * 32;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic        func;
      logic [31:0] position;
      logic [15:0] idx [4];
   } conv_word_type;

   typedef struct {
      logic [31:0] position;
      logic [15:0] idx [4];
   } conv_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [31:0] req_position_in;
   logic [15:0] req_index_in_0, req_index_in_1, req_index_in_2, req_index_in_3;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_position_out;
   logic [15:0] rsp_index_out_0, rsp_index_out_1, rsp_index_out_2, rsp_index_out_3;
   logic        csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [15:0] csr_wdata;

   // shadow of the converter's registers
   logic [2:0]  shadow_count;
   logic [15:0] shadow_size [4];

   conv_result_type expected_results [$];
   int unsigned  mismatch_count;
   int unsigned  words_sent;
   int unsigned  words_checked;
   int unsigned  idle_cycles;
   bit           stall_long;
   bit           rsp_gaps_on;
   bit           timed_out;

   array_position_index_converter_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_position_in(req_position_in),
      .req_index_in_0(req_index_in_0), .req_index_in_1(req_index_in_1),
      .req_index_in_2(req_index_in_2), .req_index_in_3(req_index_in_3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_position_out(rsp_position_out),
      .rsp_index_out_0(rsp_index_out_0), .rsp_index_out_1(rsp_index_out_1),
      .rsp_index_out_2(rsp_index_out_2), .rsp_index_out_3(rsp_index_out_3),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predict the converter's result for one word
   function automatic conv_result_type convert_word(conv_word_type w);
      conv_result_type r;
      int unsigned  dims;
      logic [63:0]  lo, hi, rem, q, sz, acc, stride;
      bit           lo_big, hi_big;
      r.position = '0;
      for (int k = 0; k < 4; k++) r.idx[k] = '0;
      dims = (shadow_count == 0) ? 1 : (shadow_count > 4 ? 4 : shadow_count);
      if (!w.func) begin
         lo = 64'd1;
         lo_big = 1'b0;
         for (int k = 0; k < dims; k++) begin
            sz = (shadow_size[k] == 0) ? 64'd1 : 64'(shadow_size[k]);
            hi = '0;
            hi_big = lo_big;
            if (!hi_big) begin
               if (lo > 64'hFFFF_FFFF_FFFF_FFFF / sz) hi_big = 1'b1;
               else hi = lo * sz;
            end
            rem = hi_big ? 64'(w.position) : 64'(w.position) % hi;
            q = lo_big ? 64'd0 : rem / lo;
            r.idx[k] = 16'(q + 64'd1);
            lo = hi;
            lo_big = hi_big;
         end
      end else begin
         acc = '0;
         stride = 64'd1;
         for (int k = 0; k < dims; k++) begin
            acc += stride * (64'(w.idx[k]) - 64'd1);
            stride *= (shadow_size[k] == 0) ? 64'd1 : 64'(shadow_size[k]);
         end
         r.position = acc[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on word %0d field %s: got %h want %h",
               words_checked, field, got, want);
      mismatch_count++;
   endtask

   // write one register while the converter is idle
   task automatic write_csr(csr_index_type which, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (which == CSR_DIM_COUNT) shadow_count = value[2:0];
      else shadow_size[which - 1] = value;
   endtask

   task automatic set_shape(logic [15:0] count, logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2, logic [15:0] s3);
      write_csr(CSR_DIM_COUNT, count);
      write_csr(CSR_DIM_SIZE_0, s0);
      write_csr(CSR_DIM_SIZE_1, s1);
      write_csr(CSR_DIM_SIZE_2, s2);
      write_csr(CSR_DIM_SIZE_3, s3);
   endtask

   // drop valid over the gap, offer one word until accepted, and queue its result;
   // valid stays high after acceptance so a following word can go back to back
   task automatic send_word(conv_word_type w, int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= w.func;
      req_position_in <= w.position;
      req_index_in_0  <= w.idx[0];
      req_index_in_1  <= w.idx[1];
      req_index_in_2  <= w.idx[2];
      req_index_in_3  <= w.idx[3];
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(convert_word(w));
      words_sent++;
   endtask

   // stop offering and wait until every expected result has come
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_results.size() != 0 && !timed_out) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic conv_word_type random_word(int unsigned style);
      conv_word_type w;
      w.func = 1'($urandom_range(0, 1));
      w.position = $urandom();
      for (int k = 0; k < 4; k++) w.idx[k] = 16'($urandom());
      if (style < 80) begin
         // mostly in-range indices and, for half of those, positions below 4096
         for (int k = 0; k < 4; k++)
            w.idx[k] = (shadow_size[k] <= 1) ? 16'd1 : 16'($urandom_range(1, shadow_size[k]));
         if (style < 40) w.position = $urandom_range(0, 4095);
      end
      return w;
   endfunction

   // result side: random back-pressure, one long hold-off on request
   initial begin
      int unsigned roll;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_long) begin
            rsp_ready <= 1'b0;
            repeat (LATENCY + 300) @(posedge clock);
            stall_long = 1'b0;
         end
         roll = $urandom_range(0, 99);
         if (!rsp_gaps_on || roll < 70) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            repeat ((roll < 97) ? $urandom_range(1, 3) : $urandom_range(10, 40))
               @(posedge clock);
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // check every accepted result against the oldest prediction
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("none outstanding", rsp_position_out, 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_position_out !== want.position)
               report_mismatch("position_out", rsp_position_out, want.position);
            if (rsp_index_out_0 !== want.idx[0])
               report_mismatch("index_out_0", 32'(rsp_index_out_0), 32'(want.idx[0]));
            if (rsp_index_out_1 !== want.idx[1])
               report_mismatch("index_out_1", 32'(rsp_index_out_1), 32'(want.idx[1]));
            if (rsp_index_out_2 !== want.idx[2])
               report_mismatch("index_out_2", 32'(rsp_index_out_2), 32'(want.idx[2]));
            if (rsp_index_out_3 !== want.idx[3])
               report_mismatch("index_out_3", 32'(rsp_index_out_3), 32'(want.idx[3]));
         end
         words_checked++;
      end
   end

   // watchdog: count cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("[array_position_index_converter_top] ERROR");
         $finish;
      end
   end

   // directed rows: shape, word, and for typed rows the result
   typedef struct {
      logic [15:0]     count;
      logic [15:0]     sizes [4];
      conv_word_type   w;
      bit              typed;
      conv_result_type r;
   } directed_row_type;

   directed_row_type directed_rows [$];

   function automatic directed_row_type row(logic [15:0] cnt, logic [15:0] s0,
                                            logic [15:0] s1, logic [15:0] s2,
                                            logic [15:0] s3, logic fn, logic [31:0] pos,
                                            logic [15:0] i0, logic [15:0] i1,
                                            logic [15:0] i2, logic [15:0] i3);
      directed_row_type d;
      d.count = cnt;
      d.sizes = '{s0, s1, s2, s3};
      d.w.func = fn;
      d.w.position = pos;
      d.w.idx = '{i0, i1, i2, i3};
      d.typed = 1'b0;
      return d;
   endfunction

   initial begin
      directed_row_type d;
      int unsigned      phase_words;
      bit               shape_change;
      logic [15:0]      prev_count;
      logic [15:0]      prev_sizes [4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_position_in = '0;
      req_index_in_0 = '0;
      req_index_in_1 = '0;
      req_index_in_2 = '0;
      req_index_in_3 = '0;
      csr_we = 1'b0;
      csr_index = CSR_DIM_COUNT;
      csr_wdata = '0;
      mismatch_count = 0;
      words_sent = 0;
      words_checked = 0;
      idle_cycles = 0;
      stall_long = 1'b0;
      rsp_gaps_on = 1'b0;
      timed_out = 1'b0;
      shadow_count = 3'd1;
      for (int k = 0; k < 4; k++) shadow_size[k] = 16'd1;
      prev_count = 16'd1;
      for (int k = 0; k < 4; k++) prev_sizes[k] = 16'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: one dimension of size one, registers left untouched
      d = row(1, 1, 1, 1, 1, 1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      d.typed = 1'b1;
      d.r.position = '0;
      d.r.idx = '{16'd1, 16'd0, 16'd0, 16'd0};
      directed_rows.push_back(d);
      // an index of zero wraps the position to all ones
      d = row(1, 1, 1, 1, 1, 1'b1, 0, 16'd0, 16'hFFFF, 0, 0);
      d.typed = 1'b1;
      d.r.position = 32'hFFFF_FFFF;
      d.r.idx = '{16'd0, 16'd0, 16'd0, 16'd0};
      directed_rows.push_back(d);

      // remaining directed rows: extremes, zero sizes, count out of range, wraps
      directed_rows.push_back(row(4, 2, 3, 4, 5, 1'b0, 32'd0, 0, 0, 0, 0));
      directed_rows.push_back(row(4, 2, 3, 4, 5, 1'b0, 32'd119, 0, 0, 0, 0));
      directed_rows.push_back(row(4, 2, 3, 4, 5, 1'b0, 32'd120, 0, 0, 0, 0));
      directed_rows.push_back(row(4, 2, 3, 4, 5, 1'b1, 0, 16'd2, 16'd3, 16'd4, 16'd5));
      directed_rows.push_back(row(4, 2, 3, 4, 5, 1'b1, 0, 16'd0, 16'd0, 16'd0, 16'd0));
      directed_rows.push_back(row(0, 7, 0, 0, 0, 1'b0, 32'd20, 0, 0, 0, 0));
      directed_rows.push_back(row(0, 7, 0, 0, 0, 1'b1, 0, 16'd3, 16'd9, 16'd9, 16'd9));
      directed_rows.push_back(row(7, 0, 0, 0, 0, 1'b0, 32'hDEAD_BEEF, 0, 0, 0, 0));
      directed_rows.push_back(row(7, 0, 5, 0, 3, 1'b1, 0, 16'd1, 16'd5, 16'd1, 16'd3));
      directed_rows.push_back(row(5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
                                  32'hFFFF_FFFF, 0, 0, 0, 0));
      directed_rows.push_back(row(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
                                  32'h1234_5678, 0, 0, 0, 0));
      directed_rows.push_back(row(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                  0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      directed_rows.push_back(row(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                  0, 16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF));
      directed_rows.push_back(row(2, 16'd1, 16'hFFFF, 1, 1, 1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0));
      directed_rows.push_back(row(3, 16'd256, 16'd256, 16'd256, 1, 1'b0,
                                  32'hFFFF_FFFF, 0, 0, 0, 0));
      directed_rows.push_back(row(3, 16'd256, 16'd256, 16'd256, 1, 1'b1,
                                  0, 16'h5555, 16'hAAAA, 16'h0001, 16'h1234));

      // walk the table; rewrite the shape only when it changes
      foreach (directed_rows[i]) begin
         d = directed_rows[i];
         shape_change = (d.count != prev_count);
         for (int k = 0; k < 4; k++)
            if (d.sizes[k] != prev_sizes[k]) shape_change = 1'b1;
         if (shape_change) begin
            drain();
            set_shape(d.count, d.sizes[0], d.sizes[1], d.sizes[2], d.sizes[3]);
            prev_count = d.count;
            for (int k = 0; k < 4; k++) prev_sizes[k] = d.sizes[k];
         end
         send_word(d.w, 0);
         if (d.typed) expected_results[$] = d.r;
      end
      drain();

      // random phases over a range of shapes, with gaps on both sides
      rsp_gaps_on = 1'b1;
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: set_shape(16'($urandom_range(0, 7)), 16'($urandom_range(1, 8)),
                         16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                         16'($urandom_range(1, 8)));
            1: set_shape(16'd4, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()));
            2: set_shape(16'($urandom_range(1, 4)), 16'($urandom_range(0, 300)),
                         16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                         16'($urandom_range(0, 300)));
            default: set_shape(16'($urandom_range(0, 7)), 16'hFFFF,
                               16'($urandom_range(0, 2)), 16'hFFFF, 16'($urandom()));
         endcase
         phase_words = 95;
         for (int n = 0; n < phase_words; n++) begin
            // hold results back once so the pipeline fills and stalls its input
            if (ph == 5 && n == 10) stall_long = 1'b1;
            // and once let everything drain before going on
            if (ph == 9 && n == 50) drain();
            send_word(random_word($urandom_range(0, 99)), (n % 30 < 20) ? pick_gap() : 0);
         end
         drain();
         repeat (LATENCY) @(posedge clock);
      end

      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d words, checked %0d results across directed rows and 16 shapes",
               words_sent, words_checked);
      $display("covered both directions, zero and out-of-range counts, zero and full sizes");
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("[array_position_index_converter_top] OK");
      else
         $display("[array_position_index_converter_top] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/apic_pkg.sv
rtl/apic_csr.sv
rtl/array_position_index_converter_top.sv
rtl/apic_checker.sv
test/tb.sv
